@@ rtl/mfrq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfrq_pkg
// Shared codes, field widths and cell control type of the ready queue.
// ----------------------------------------------------------------------------
package mfrq_pkg;

  // fixed field widths
  localparam int ID_W   = 5;
  localparam int PRIO_W = 8;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ENQ    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PICK   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_QUEUED   = 2'd3;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // insert new entry behind the last one of its level
    logic pop;   // shift toward the head, dropping the head entry
    logic mark;  // capture whether this cell holds the entry to remove
    logic del;   // close the gap at the marked cell
  } ctl_t;

endpackage
`default_nettype wire

@@ rtl/mfrq_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfrq_cell
// One slot of the sorted queue chain: holds a task and its level and moves
// entries to or from its neighbors on insert, pop and delete.
// ----------------------------------------------------------------------------
module mfrq_cell
  import mfrq_pkg::*;
#(
  parameter int LVL_W = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ctl_t             ctl,
  input  wire logic [ID_W-1:0]  new_task,
  input  wire logic [LVL_W-1:0] new_lvl,
  input  wire logic             left_valid,
  input  wire logic [ID_W-1:0]  left_task,
  input  wire logic [LVL_W-1:0] left_lvl,
  input  wire logic             right_valid,
  input  wire logic [ID_W-1:0]  right_task,
  input  wire logic [LVL_W-1:0] right_lvl,
  input  wire logic             go_in,
  output logic                  go_out,
  input  wire logic             del_in,
  output logic                  del_out,
  output logic                  cur_valid,
  output logic [ID_W-1:0]       cur_task,
  output logic [LVL_W-1:0]      cur_lvl
);

  logic             valid_r, valid_nxt;
  logic [ID_W-1:0]  task_r, task_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic             hit_r, hit_nxt;
  logic             go;
  logic             del_here;

  // insert point: first empty slot or first entry of a later level
  assign go       = !valid_r || (lvl_r > new_lvl);
  assign go_out   = go;
  assign del_here = del_in || hit_r;
  assign del_out  = del_here;

  // next entry from the operation and the neighbors
  always_comb begin
    valid_nxt = valid_r;
    task_nxt  = task_r;
    lvl_nxt   = lvl_r;
    hit_nxt   = hit_r;
    if (ctl.ins) begin
      if (go && go_in) begin
        valid_nxt = left_valid;
        task_nxt  = left_task;
        lvl_nxt   = left_lvl;
      end else if (go) begin
        valid_nxt = 1'b1;
        task_nxt  = new_task;
        lvl_nxt   = new_lvl;
      end
    end else if (ctl.pop || (ctl.del && del_here)) begin
      valid_nxt = right_valid;
      task_nxt  = right_task;
      lvl_nxt   = right_lvl;
    end
    if (ctl.mark) begin
      hit_nxt = valid_r && (task_r == new_task) && (lvl_r == new_lvl);
    end else if (ctl.del) begin
      hit_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    task_r <= task_nxt;
    lvl_r  <= lvl_nxt;
  end

  assign cur_valid = valid_r;
  assign cur_task  = task_r;
  assign cur_lvl   = lvl_r;

endmodule
`default_nettype wire

@@ rtl/multilevel_fifo_ready_queue.sv @@
`default_nettype none
// Enqueue and pick results are registered and appear in the cycle after acceptance;
// remove results follow match capture, then gap closing in the chain.
// Throughput: one enqueue or pick per cycle while the result register is free or
// being read; a remove holds off new requests until its two-step delete is done.
// Reset (synchronous, active low) clears cell valid bits, queued flags and the
// result valid bit; no clearing pass is needed.
// ----------------------------------------------------------------------------
// multilevel_fifo_ready_queue
// Ready queue of task ids kept as a chain of cells sorted by level and, within
// a level, by arrival; the head cell is always the next task to run.
// ----------------------------------------------------------------------------
module multilevel_fifo_ready_queue
  import mfrq_pkg::*;
#(
  parameter int LEVELS = 8,
  parameter int TASKS  = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [REQ_W-1:0]         in_req_type,
  input  wire logic [ID_W-1:0]          in_task_id,
  input  wire logic signed [PRIO_W-1:0] in_priority_req,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [STAT_W-1:0]             out_status,
  output logic [ID_W-1:0]               out_picked_task
);

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int TASK_W = $clog2(TASKS);
  localparam int CELLS  = (TASKS < 32) ? TASKS : 32;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DEL  = 1'b1;

  logic              st_r, st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]   out_picked_r, out_picked_nxt;
  logic [TASKS-1:0]  queued_r, queued_nxt;
  logic [TASK_W-1:0] rm_idx_r, rm_idx_nxt;

  logic              accept;
  logic [8:0]        tid_ext;
  logic [8:0]        head_ext;
  logic              in_range;
  logic [TASK_W-1:0] tid_idx;
  logic [TASK_W-1:0] head_idx;
  logic [LVL_W-1:0]  lvl;
  logic              enq_ok;
  ctl_t              ctl;

  logic             c_valid [CELLS];
  logic [ID_W-1:0]  c_task  [CELLS];
  logic [LVL_W-1:0] c_lvl   [CELLS];
  logic             c_go    [CELLS];
  logic             c_del   [CELLS];

  assign accept = in_valid && in_ready;
  assign in_ready = (st_r == S_IDLE) && (!out_valid_r || out_ready);

  // task id to queued flag index
  assign tid_ext  = {4'b0, in_task_id};
  assign head_ext = {4'b0, c_task[0]};
  assign in_range = tid_ext < 9'(TASKS);
  assign tid_idx  = tid_ext[TASK_W-1:0];
  assign head_idx = head_ext[TASK_W-1:0];

  // priority clamp into 0..LEVELS-1
  always_comb begin
    if (in_priority_req[PRIO_W-1]) begin
      lvl = '0;
    end else if (in_priority_req > $signed(PRIO_W'(LEVELS - 1))) begin
      lvl = LVL_W'(LEVELS - 1);
    end else begin
      lvl = in_priority_req[LVL_W-1:0];
    end
  end

  assign enq_ok = in_range && !queued_r[tid_idx];

  // chain operation
  always_comb begin
    ctl.ins  = accept && (in_req_type == REQ_ENQ) && enq_ok;
    ctl.pop  = accept && (in_req_type == REQ_PICK) && c_valid[0];
    ctl.mark = accept && (in_req_type == REQ_REMOVE);
    ctl.del  = (st_r == S_DEL);
  end

  // cell chain, head at index zero
  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    logic             lv, rv, gi, di;
    logic [ID_W-1:0]  lt, rt;
    logic [LVL_W-1:0] ll, rl;
    if (j == 0) begin : g_first
      assign lv = 1'b0;
      assign lt = '0;
      assign ll = '0;
      assign gi = 1'b0;
      assign di = 1'b0;
    end else begin : g_mid
      assign lv = c_valid[j-1];
      assign lt = c_task[j-1];
      assign ll = c_lvl[j-1];
      assign gi = c_go[j-1];
      assign di = c_del[j-1];
    end
    if (j == CELLS - 1) begin : g_last
      assign rv = 1'b0;
      assign rt = '0;
      assign rl = '0;
    end else begin : g_inner
      assign rv = c_valid[j+1];
      assign rt = c_task[j+1];
      assign rl = c_lvl[j+1];
    end
    mfrq_cell #(
      .LVL_W(LVL_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_task   (in_task_id),
      .new_lvl    (lvl),
      .left_valid (lv),
      .left_task  (lt),
      .left_lvl   (ll),
      .right_valid(rv),
      .right_task (rt),
      .right_lvl  (rl),
      .go_in      (gi),
      .go_out     (c_go[j]),
      .del_in     (di),
      .del_out    (c_del[j]),
      .cur_valid  (c_valid[j]),
      .cur_task   (c_task[j]),
      .cur_lvl    (c_lvl[j])
    );
  end

  // sequencing, queued flags and result register
  always_comb begin
    st_nxt         = st_r;
    queued_nxt     = queued_r;
    rm_idx_nxt     = rm_idx_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_picked_nxt = out_picked_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      unique case (in_req_type)
        REQ_ENQ: begin
          out_valid_nxt  = 1'b1;
          out_picked_nxt = '0;
          if (enq_ok) begin
            queued_nxt[tid_idx] = 1'b1;
            out_status_nxt      = STAT_OK;
          end else begin
            out_status_nxt = STAT_QUEUED;
          end
        end
        REQ_REMOVE: begin
          st_nxt     = S_DEL;
          rm_idx_nxt = tid_idx;
        end
        REQ_PICK: begin
          out_valid_nxt = 1'b1;
          if (c_valid[0]) begin
            queued_nxt[head_idx] = 1'b0;
            out_status_nxt       = STAT_OK;
            out_picked_nxt       = c_task[0];
          end else begin
            out_status_nxt = STAT_EMPTY;
            out_picked_nxt = '0;
          end
        end
        default: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_picked_nxt = '0;
        end
      endcase
    end
    if (st_r == S_DEL) begin
      st_nxt         = S_IDLE;
      out_valid_nxt  = 1'b1;
      out_picked_nxt = '0;
      if (c_del[CELLS-1]) begin
        queued_nxt[rm_idx_r] = 1'b0;
        out_status_nxt       = STAT_OK;
      end else begin
        out_status_nxt = STAT_NOTFOUND;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      queued_r    <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      queued_r    <= queued_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rm_idx_r     <= rm_idx_nxt;
    out_status_r <= out_status_nxt;
    out_picked_r <= out_picked_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_picked_task = out_picked_r;

endmodule
`default_nettype wire

@@ bench/tb_multilevel_fifo_ready_queue.sv @@
// ----------------------------------------------------------------------------
// tb_multilevel_fifo_ready_queue
// Self-checking bench for the multilevel ready queue: directed checks of empty
// picks, priority clamping and list edits, then random enqueue/remove/pick
// traffic. A behavioral model of the per-level lists predicts every result,
// and both handshakes are throttled: requests at random, results by cycling stall modes.
// ----------------------------------------------------------------------------
module tb_multilevel_fifo_ready_queue
  import mfrq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LEVELS   = 8;
  localparam int NUM_TASKS    = 32;
  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   picked;
  } sched_result_t;

  // dut ports, inputs all known from time zero
  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     in_valid        = 1'b0;
  logic                     in_ready;
  logic [REQ_W-1:0]         in_req_type     = REQ_NONE;
  logic [ID_W-1:0]          in_task_id      = '0;
  logic signed [PRIO_W-1:0] in_priority_req = '0;
  logic                     out_valid;
  logic                     out_ready       = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic [ID_W-1:0]          out_picked_task;

  // predicted queue contents and bookkeeping
  logic [ID_W-1:0] level_fifo [NUM_LEVELS][$];
  bit              on_queue   [NUM_TASKS];
  int              task_level [NUM_TASKS];
  sched_result_t   expected_results [$];
  int              mismatches  = 0;
  int              burst_left  = 0;
  int              cycle_count = 0;
  int              stall_count = 0;

  multilevel_fifo_ready_queue #(
    .LEVELS(NUM_LEVELS),
    .TASKS (NUM_TASKS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_task_id     (in_task_id),
    .in_priority_req(in_priority_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_picked_task(out_picked_task)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // next state of the ready queue and the answer for one request
  function automatic sched_result_t predict_ready_queue(input logic [REQ_W-1:0] req,
                                                        input logic [ID_W-1:0] id,
                                                        input logic signed [PRIO_W-1:0] prio);
    sched_result_t res;
    int            lv;
    int            hit;
    res = '{status: STAT_OK, picked: '0};
    if (prio < 0) lv = 0;
    else if (prio > NUM_LEVELS - 1) lv = NUM_LEVELS - 1;
    else lv = int'(prio);
    case (req)
      REQ_ENQ: begin
        if (on_queue[id]) begin
          res.status = STAT_QUEUED;
        end else begin
          level_fifo[lv].push_back(id);
          on_queue[id]   = 1'b1;
          task_level[id] = lv;
        end
      end
      REQ_REMOVE: begin
        hit = -1;
        for (int i = 0; i < level_fifo[lv].size(); i++) begin
          if (hit < 0 && level_fifo[lv][i] == id) hit = i;
        end
        if (hit < 0) begin
          res.status = STAT_NOTFOUND;
        end else begin
          level_fifo[lv].delete(hit);
          on_queue[id] = 1'b0;
        end
      end
      REQ_PICK: begin
        res.status = STAT_EMPTY;
        for (int l = 0; l < NUM_LEVELS; l++) begin
          if (res.status == STAT_EMPTY && level_fifo[l].size() != 0) begin
            res.status         = STAT_OK;
            res.picked         = level_fifo[l].pop_front();
            on_queue[res.picked] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // send one transaction, then maybe leave a gap
  task automatic issue_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                               input logic signed [PRIO_W-1:0] prio);
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_task_id      <= id;
    in_priority_req <= prio;
    // ready is stable between edges, so look at it mid-cycle
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    expected_results.push_back(predict_ready_queue(req, id, prio));
    if (burst_left == 0) begin
      in_valid   <= 1'b0;
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 8);
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // hold the sender until every outstanding result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    issue_request(REQ_PICK, 5'd0, 8'sd0);
    issue_request(REQ_REMOVE, 5'd5, 8'sd0);
    issue_request(REQ_NONE, 5'd31, -8'sd1);
    wait_for_results();
  endtask

  task automatic test_priority_clamp();
    issue_request(REQ_ENQ, 5'd1, -8'sd128);
    issue_request(REQ_ENQ, 5'd2, 8'sd127);
    issue_request(REQ_ENQ, 5'd3, -8'sd1);
    issue_request(REQ_ENQ, 5'd4, 8'sd3);
    repeat (4) issue_request(REQ_PICK, 5'd31, 8'sd0);
    wait_for_results();
  endtask

  task automatic test_list_edits();
    for (int t = 10; t < 14; t++) issue_request(REQ_ENQ, ID_W'(t), 8'sd2);
    // double enqueue, then remove at a level the task is not on
    issue_request(REQ_ENQ, 5'd11, 8'sd5);
    issue_request(REQ_REMOVE, 5'd12, 8'sd4);
    // middle, head and tail removes
    issue_request(REQ_REMOVE, 5'd12, 8'sd2);
    issue_request(REQ_REMOVE, 5'd10, 8'sd2);
    issue_request(REQ_REMOVE, 5'd13, 8'sd2);
    issue_request(REQ_PICK, 5'd0, 8'sd0);
    issue_request(REQ_PICK, 5'd0, 8'sd0);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    logic [ID_W-1:0]          free_ids [$];
    logic [ID_W-1:0]          busy_ids [$];
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
    int                       roll;
    int                       enq_pct;
    int                       lv;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      free_ids.delete();
      busy_ids.delete();
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (on_queue[t]) busy_ids.push_back(ID_W'(t));
        else free_ids.push_back(ID_W'(t));
      end
      // alternate fill-heavy and drain-heavy stretches
      enq_pct = ((n / 50) % 2 == 0) ? 60 : 25;
      roll    = $urandom_range(0, 99);
      id      = ID_W'($urandom_range(0, NUM_TASKS - 1));
      prio    = ($urandom_range(0, 4) == 0) ? PRIO_W'($urandom)
                                            : PRIO_W'($urandom_range(0, NUM_LEVELS - 1));
      if (roll < enq_pct) begin
        if (free_ids.size() != 0 && $urandom_range(0, 99) < 85)
          id = free_ids[$urandom_range(0, free_ids.size() - 1)];
        issue_request(REQ_ENQ, id, prio);
      end else if (roll < enq_pct + 20) begin
        if (busy_ids.size() != 0 && $urandom_range(0, 99) < 70) begin
          id   = busy_ids[$urandom_range(0, busy_ids.size() - 1)];
          lv   = task_level[id];
          prio = PRIO_W'(lv);
          // reach the end levels through out-of-range priorities too
          if (lv == 0 && $urandom_range(0, 1) == 1)
            prio = -PRIO_W'($urandom_range(1, 128));
          else if (lv == NUM_LEVELS - 1 && $urandom_range(0, 1) == 1)
            prio = PRIO_W'($urandom_range(NUM_LEVELS - 1, 127));
        end
        issue_request(REQ_REMOVE, id, prio);
      end else if (roll < 96) begin
        issue_request(REQ_PICK, id, prio);
      end else begin
        issue_request(REQ_NONE, id, prio);
      end
      if (n % 100 == 99) wait_for_results();
    end
    wait_for_results();
  endtask

  // receiver backpressure, cycling through its own stall modes
  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    case (stall_count[8:7])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
      2'd2:    out_ready <= (stall_count[1:0] == 2'd0);
      default: out_ready <= (stall_count[4:3] == 2'd0);
    endcase
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    sched_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d picked=%0d",
                 $time, out_status, out_picked_task);
        mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, out_status);
          mismatches++;
        end
        if (out_picked_task !== exp_res.picked) begin
          $display("%0t: picked_task expected %0d actual %0d",
                   $time, exp_res.picked, out_picked_task);
          mismatches++;
        end
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_priority_clamp();
    test_list_edits();
    test_random_traffic();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
